// ===== design/fjr_pkg.sv =====
// Shared types and constants for the feeder jam reverse tracker.
// No dependencies; imported by every module of the block.
package fjr_pkg;

	localparam int CFG_DATA_W = 31;
	localparam int CFG_IDX_W  = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STALL_THRESH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DUR    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SPEED  = 3'd4;

	localparam logic [15:0]        CHECK_INTERVAL_RST = 16'd100;
	localparam logic [30:0]        STALL_THRESH_RST   = 31'd1000;
	localparam logic [15:0]        REVERSE_DUR_RST    = 16'd500;
	localparam logic signed [14:0] FORWARD_SPEED_RST  = -15'sd2500;
	localparam logic signed [14:0] REVERSE_SPEED_RST  = 15'sd1000;

	typedef struct packed {
		logic [15:0]        check_interval_ms;
		logic [30:0]        stall_angle_threshold;
		logic [15:0]        reverse_duration_ms;
		logic signed [14:0] forward_speed;
		logic signed [14:0] reverse_speed;
	} fjr_cfg_t;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic signed [31:0] total_angle;
		logic               feed_enable;
	} fjr_in_t;

	typedef struct packed {
		logic signed [14:0] target_speed;
		logic               reversing;
		logic signed [31:0] fed_angle_total;
		logic [31:0]        cooling_ms_total;
	} fjr_out_t;

endpackage

// ===== design/feeder_jam_reverse_tracker.sv =====
// Feeder jam reverse tracker, top level: input register, tracker core,
// configuration registers and result register. Depends on fjr_pkg,
// fjr_cfg and fjr_core.
//
// One input beat per control tick gives exactly one result beat. A beat is
// captured in the input register, the next tracker state is computed from it
// combinationally and stored as it advances, and the result lands in the output
// register, so the result passes the input register and then the output register;
// a new beat can be taken every cycle while the output is not stalled.
// While a result waits in the output register the input register takes one
// more beat and then holds in_stall high until the result is taken.
// Configuration is written through cfg_we/cfg_index/cfg_data and should only
// change while idle.
module feeder_jam_reverse_tracker import fjr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  fjr_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output fjr_out_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	fjr_cfg_t cfg;
	fjr_in_t  item_s1;
	logic     valid_s1;
	logic     advance;
	fjr_out_t result;

	fjr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fjr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.item    (item_s1),
		.result  (result)
	);

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= result;
		end
	end

endmodule

// ===== design/fjr_cfg.sv =====
// Configuration register file of the feeder jam reverse tracker.
// Depends on fjr_pkg for register indexes, reset values and fjr_cfg_t.
module fjr_cfg import fjr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output fjr_cfg_t              cfg
);

	fjr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_interval_ms     <= CHECK_INTERVAL_RST;
			cfg_q.stall_angle_threshold <= STALL_THRESH_RST;
			cfg_q.reverse_duration_ms   <= REVERSE_DUR_RST;
			cfg_q.forward_speed         <= FORWARD_SPEED_RST;
			cfg_q.reverse_speed         <= REVERSE_SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHECK_INTERVAL: cfg_q.check_interval_ms     <= cfg_data[15:0];
				REG_STALL_THRESH:   cfg_q.stall_angle_threshold <= cfg_data[30:0];
				REG_REVERSE_DUR:    cfg_q.reverse_duration_ms   <= cfg_data[15:0];
				REG_FORWARD_SPEED:  cfg_q.forward_speed         <= cfg_data[14:0];
				REG_REVERSE_SPEED:  cfg_q.reverse_speed         <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/fjr_core.sv =====
// Tracker state and per-tick update logic: feed accounting, cooling time,
// stall check and timed reverse. Depends on fjr_pkg.
module fjr_core import fjr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  fjr_cfg_t cfg,
	input  logic     advance,
	input  fjr_in_t  item,
	output fjr_out_t result
);

	logic [31:0] last_check_ms_q, last_check_angle_q, reverse_start_ms_q;
	logic [31:0] forward_ref_q, last_cool_ms_q, fed_acc_q, cooling_acc_q;
	logic        reverse_q, forward_ref_vld_q, last_cool_vld_q;

	logic [31:0] last_check_ms_d, last_check_angle_d, reverse_start_ms_d;
	logic [31:0] forward_ref_d, last_cool_ms_d, fed_acc_d, cooling_acc_d;
	logic        reverse_d, forward_ref_vld_d, last_cool_vld_d;

	logic [31:0]        now, angle, fref, lcool, diff, mag;
	logic               check_due;
	logic signed [14:0] target;

	always_comb begin
		now   = item.now_ms;
		angle = item.total_angle;
		fref  = forward_ref_vld_q ? forward_ref_q : angle;
		lcool = last_cool_vld_q ? last_cool_ms_q : now;
		diff  = angle - last_check_angle_q;
		mag   = diff[31] ? (32'd0 - diff) : diff;
		check_due = (now - last_check_ms_q) >= {16'd0, cfg.check_interval_ms};

		last_check_ms_d    = last_check_ms_q;
		last_check_angle_d = last_check_angle_q;
		reverse_start_ms_d = reverse_start_ms_q;
		forward_ref_d      = angle;
		forward_ref_vld_d  = 1'b1;
		last_cool_ms_d     = last_cool_ms_q;
		last_cool_vld_d    = last_cool_vld_q;
		fed_acc_d          = fed_acc_q;
		cooling_acc_d      = cooling_acc_q;
		reverse_d          = reverse_q;
		target             = '0;

		if (item.feed_enable) begin
			cooling_acc_d   = cooling_acc_q + (now - lcool);
			last_cool_ms_d  = now;
			last_cool_vld_d = 1'b1;

			// reference holds while reversing; it moves on when feeding forwards or at reverse end
			forward_ref_d = fref;
			if (!reverse_q) begin
				target        = cfg.forward_speed;
				fed_acc_d     = fed_acc_q + (fref - angle);
				forward_ref_d = angle;
			end

			if (check_due) begin
				if (mag < {1'b0, cfg.stall_angle_threshold} && !reverse_q) begin
					reverse_d          = 1'b1;
					reverse_start_ms_d = now;
					target             = cfg.reverse_speed;
				end
				last_check_ms_d    = now;
				last_check_angle_d = angle;
			end

			// reverse end keeps whatever target was set this tick
			if (reverse_d) begin
				if ((now - reverse_start_ms_d) >= {16'd0, cfg.reverse_duration_ms}) begin
					reverse_d     = 1'b0;
					forward_ref_d = angle;
				end else begin
					target = cfg.reverse_speed;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_check_ms_q    <= '0;
			last_check_angle_q <= '0;
			reverse_start_ms_q <= '0;
			forward_ref_q      <= '0;
			last_cool_ms_q     <= '0;
			fed_acc_q          <= '0;
			cooling_acc_q      <= '0;
			reverse_q          <= 1'b0;
			forward_ref_vld_q  <= 1'b0;
			last_cool_vld_q    <= 1'b0;
		end else if (advance) begin
			last_check_ms_q    <= last_check_ms_d;
			last_check_angle_q <= last_check_angle_d;
			reverse_start_ms_q <= reverse_start_ms_d;
			forward_ref_q      <= forward_ref_d;
			last_cool_ms_q     <= last_cool_ms_d;
			fed_acc_q          <= fed_acc_d;
			cooling_acc_q      <= cooling_acc_d;
			reverse_q          <= reverse_d;
			forward_ref_vld_q  <= forward_ref_vld_d;
			last_cool_vld_q    <= last_cool_vld_d;
		end
	end

	always_comb begin
		result.target_speed     = target;
		result.reversing        = reverse_d;
		result.fed_angle_total  = fed_acc_d;
		result.cooling_ms_total = cooling_acc_d;
	end

endmodule
